@@ rtl/core/signed_decimal_to_ascii_defines.svh @@
// assertion macros for the signed decimal to ascii printer
// used by the top level only, no other dependencies
`ifndef SIGNED_DECIMAL_TO_ASCII_DEFINES_SVH
`define SIGNED_DECIMAL_TO_ASCII_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SDA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sda assertion failed");

// next-cycle implication, checked outside reset
`define SDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sda assertion failed");

`endif

@@ rtl/core/sda_pkg.sv @@
// shared types and constants of the signed decimal to ascii printer
// no dependencies
package sda_pkg;

    localparam int NUM_DIGITS = 20;
    localparam int BCD_W      = NUM_DIGITS * 4;
    localparam int VALUE_W    = 64;
    localparam int COUNT_W    = 5;
    localparam int STEP_W     = 5;
    localparam int CONV_STEPS = 32;

    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;

    typedef logic [3:0] bcd_digit_t;

    // one converted item waiting to be printed
    typedef struct packed {
        logic                             neg;
        logic [COUNT_W-1:0]               ndig;
        bcd_digit_t [NUM_DIGITS-1:0]      digits;
    } sda_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } sda_qstat_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CONVERT,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SIGN,
        B_DIGIT
    } back_state_t;

endpackage

@@ rtl/core/sda_front.sv @@
// front end: takes an item, forms its magnitude and converts it to bcd
// by double dabble, two bits a cycle; depends on sda_pkg
module sda_front
    import sda_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [VALUE_W-1:0] value,
    input  sda_qstat_t         qstat,
    output logic               busy,
    output logic               push,
    output sda_entry_t         entry
);

    front_state_t        state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [VALUE_W-1:0]  bin_reg, bin_next;
    logic [BCD_W-1:0]    bcd_reg, bcd_next;
    logic                neg_reg, neg_next;
    logic [BCD_W-1:0]    bcd_half;

    // add three to every digit of five or more, then shift one bit in
    function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] bcd, input logic b);
        logic [BCD_W-1:0] adj;
        begin
            for (int i = 0; i < NUM_DIGITS; i++)
            begin
                if (bcd[i*4 +: 4] >= 4'd5)
                    adj[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
                else
                    adj[i*4 +: 4] = bcd[i*4 +: 4];
            end
            return {adj[BCD_W-2:0], b};
        end
    endfunction

    // digits up to the highest non-zero one, at least one
    function automatic logic [COUNT_W-1:0] digit_count(input logic [BCD_W-1:0] bcd);
        logic [COUNT_W-1:0] n;
        begin
            n = COUNT_W'(1);
            for (int i = 0; i < NUM_DIGITS; i++)
            begin
                if (bcd[i*4 +: 4] != 4'd0)
                    n = COUNT_W'(i + 1);
            end
            return n;
        end
    endfunction

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (start)
                    state_next = F_CONVERT;
            end
            F_CONVERT:
            begin
                if (step_reg == STEP_W'(CONV_STEPS - 1))
                    state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!qstat.full)
                    state_next = F_IDLE;
            end
            default:
                state_next = F_IDLE;
        endcase
    end

    assign bcd_half = dabble(bcd_reg, bin_reg[VALUE_W-1]);

    always_comb
    begin
        step_next = step_reg;
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        neg_next  = neg_reg;
        push      = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                // the minimum value negates to 2^63, which fits unsigned
                neg_next  = value[VALUE_W-1];
                bin_next  = value[VALUE_W-1] ? (~value + VALUE_W'(1)) : value;
                bcd_next  = '0;
                step_next = '0;
            end
            F_CONVERT:
            begin
                bcd_next  = dabble(bcd_half, bin_reg[VALUE_W-2]);
                bin_next  = {bin_reg[VALUE_W-3:0], 2'b00};
                step_next = step_reg + STEP_W'(1);
            end
            F_PUSH:
                push = !qstat.full;
            default:
                push = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
        neg_reg <= neg_next;
    end

    assign busy         = (state_reg != F_IDLE);
    assign entry.neg    = neg_reg;
    assign entry.ndig   = digit_count(bcd_reg);
    assign entry.digits = bcd_reg;

endmodule

@@ rtl/core/sda_queue.sv @@
// short queue of converted items between front and back end
// depends on sda_pkg
module sda_queue
    import sda_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  sda_entry_t wr_entry,
    input  logic       pop,
    output sda_entry_t rd_entry,
    output sda_qstat_t qstat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    sda_entry_t         entries_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            fill_next = fill_reg + CNT_W'(1);
        else if (pop && !push)
            fill_next = fill_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= wr_entry;
    end

    assign rd_entry    = entries_reg[rd_ptr_reg];
    assign qstat.full  = (fill_reg == CNT_W'(DEPTH));
    assign qstat.empty = (fill_reg == '0);

endmodule

@@ rtl/core/sda_back.sv @@
// back end: takes a converted item from the queue and prints it,
// sign first, one character a cycle; depends on sda_pkg
module sda_back
    import sda_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  sda_qstat_t         qstat,
    input  sda_entry_t         rd_entry,
    output logic               pop,
    output logic               strobe,
    output logic [7:0]         char_code,
    output logic               last,
    output logic [COUNT_W-1:0] char_count
);

    back_state_t         state_reg, state_next;
    sda_entry_t          ent_reg, ent_next;
    logic [COUNT_W-1:0]  idx_reg, idx_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                strobe_reg, strobe_next;
    logic [7:0]          char_reg, char_next;
    logic                last_reg, last_next;
    logic [COUNT_W-1:0]  cnt_out_reg, cnt_out_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!qstat.empty)
                    state_next = rd_entry.neg ? B_SIGN : B_DIGIT;
            end
            B_SIGN:
                state_next = B_DIGIT;
            B_DIGIT:
            begin
                if (idx_reg == '0)
                    state_next = B_IDLE;
            end
            default:
                state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        pop          = 1'b0;
        ent_next     = ent_reg;
        idx_next     = idx_reg;
        count_next   = count_reg;
        strobe_next  = 1'b0;
        char_next    = char_reg;
        last_next    = 1'b0;
        cnt_out_next = '0;
        case (state_reg)
            B_IDLE:
            begin
                pop        = !qstat.empty;
                ent_next   = rd_entry;
                idx_next   = rd_entry.ndig - COUNT_W'(1);
                count_next = rd_entry.ndig + COUNT_W'(rd_entry.neg);
            end
            B_SIGN:
            begin
                strobe_next = 1'b1;
                char_next   = ASCII_MINUS;
            end
            B_DIGIT:
            begin
                strobe_next = 1'b1;
                char_next   = ASCII_ZERO + {4'd0, ent_reg.digits[idx_reg]};
                if (idx_reg == '0)
                begin
                    last_next    = 1'b1;
                    cnt_out_next = count_reg;
                end
                else
                    idx_next = idx_reg - COUNT_W'(1);
            end
            default:
                pop = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_IDLE;
            idx_reg     <= '0;
            count_reg   <= '0;
            strobe_reg  <= 1'b0;
            last_reg    <= 1'b0;
            cnt_out_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            count_reg   <= count_next;
            strobe_reg  <= strobe_next;
            last_reg    <= last_next;
            cnt_out_reg <= cnt_out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg  <= ent_next;
        char_reg <= char_next;
    end

    assign strobe     = strobe_reg;
    assign char_code  = char_reg;
    assign last       = last_reg;
    assign char_count = cnt_out_reg;

endmodule

@@ rtl/core/signed_decimal_to_ascii.sv @@
// top level of the signed decimal to ascii printer
// depends on sda_pkg, sda_front, sda_queue, sda_back and the defines header

// Prints a signed 64-bit value as decimal ASCII, most significant character
// first, with a leading '-' for negative values (the minimum value included).
// An item is taken when start is high and busy is low; busy then stays high
// while the item runs through double dabble at two bits a cycle, has its
// digits sized and waits to be handed to the queue (held while the queue is
// full), so no new item is taken until the last one is in the queue. A queue
// of QUEUE_DEPTH converted items feeds the printer, which loads an item and
// then gives its 1 to 20 characters on consecutive cycles, each marked by
// strobe for one cycle; the receiver must take every character as it comes.
// The last character carries last and the character count.
`include "signed_decimal_to_ascii_defines.svh"

module signed_decimal_to_ascii
    import sda_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [VALUE_W-1:0] value,
    output logic               strobe,
    output logic [7:0]         char_code,
    output logic               last,
    output logic [COUNT_W-1:0] char_count
);

    sda_qstat_t qstat;
    sda_entry_t wr_entry;
    sda_entry_t rd_entry;
    logic       push;
    logic       pop;
    logic       count_ok;

    sda_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .value (value),
        .qstat (qstat),
        .busy  (busy),
        .push  (push),
        .entry (wr_entry)
    );

    sda_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (wr_entry),
        .pop      (pop),
        .rd_entry (rd_entry),
        .qstat    (qstat)
    );

    sda_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .qstat      (qstat),
        .rd_entry   (rd_entry),
        .pop        (pop),
        .strobe     (strobe),
        .char_code  (char_code),
        .last       (last),
        .char_count (char_count)
    );

    assign count_ok = (char_count != '0) && (char_count <= COUNT_W'(NUM_DIGITS));

    // a taken item keeps the front end busy while it converts
    `SDA_ASSERT_NEXT(a_busy_after_take, clk, rst_n, start && !busy, busy)
    // characters of one run come on consecutive cycles
    `SDA_ASSERT_NEXT(a_run_contiguous, clk, rst_n, strobe && !last, strobe)
    // the count on the final character is within the run lengths possible
    `SDA_ASSERT_NOW(a_count_range, clk, rst_n, strobe && last, count_ok)
    // a minus is never the final character
    `SDA_ASSERT_NOW(a_sign_not_last, clk, rst_n, strobe && (char_code == ASCII_MINUS), !last)

endmodule
